// ===== design/rm5_pkg.sv =====
`timescale 1ns / 1ps

package rm5_pkg;

  // Width of the pixel fields on the ports.
  localparam int FIELD_BITS = 16;

  // Median window and the rank of its middle element.
  localparam int WINDOW      = 5;
  localparam int MEDIAN_RANK = 2;

  // One input can cause up to three output beats.
  localparam int MAX_RESULTS = 3;
  localparam int RUN_BITS    = 2;

  // Column counter saturates once the window is full.
  localparam int          COL_BITS   = 3;
  localparam logic [2:0]  COL_ONE    = 3'd1;
  localparam logic [2:0]  COL_TWO    = 3'd2;
  localparam logic [2:0]  COL_FULL   = 3'd4;

  // Run length codes for one queued entry.
  localparam logic [1:0]  RUN_NONE   = 2'd0;
  localparam logic [1:0]  RUN_ONE    = 2'd1;
  localparam logic [1:0]  RUN_TWO    = 2'd2;
  localparam logic [1:0]  RUN_THREE  = 2'd3;

  // Control half of a queued entry: how many beats, and whether it ends a row.
  typedef struct packed {
    logic [RUN_BITS-1:0] count;
    logic                row_end;
  } run_ctl_t;

  localparam int CTL_BITS = RUN_BITS + 1;

endpackage

// ===== design/rm5_front.sv =====
`timescale 1ns / 1ps

module rm5_front import rm5_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [FIELD_BITS-1:0]             pixel,
  input  logic                              end_of_row,
  input  logic                              q_full,
  output logic                              push,
  output logic [MAX_RESULTS*PIXEL_BITS-1:0] push_pix,
  output run_ctl_t                          push_ctl
);

  logic [PIXEL_BITS-1:0] prev_out_two;
  logic [PIXEL_BITS-1:0] prev_out_one;
  logic [PIXEL_BITS-1:0] raw_first;
  logic [PIXEL_BITS-1:0] raw_second;
  logic [COL_BITS-1:0]   column_count;
  logic [COL_BITS-1:0]   column_count_next;

  logic [PIXEL_BITS-1:0] x;
  logic [PIXEL_BITS-1:0] win [WINDOW];
  logic [WINDOW-1:0]     is_mid;
  logic [PIXEL_BITS-1:0] med;
  logic [PIXEL_BITS-1:0] y;
  logic                  has_y;
  logic                  accept;
  logic [PIXEL_BITS-1:0] res [MAX_RESULTS];

  assign x        = pixel[PIXEL_BITS-1:0];
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Window of two earlier results and three raw pixels.
  assign win[0] = prev_out_two;
  assign win[1] = prev_out_one;
  assign win[2] = raw_first;
  assign win[3] = raw_second;
  assign win[4] = x;

  // Stable rank of each window element from one level of parallel compares;
  // ties are broken by position, so exactly one element holds the middle rank.
  always_comb begin
    int rank;
    for (int i = 0; i < WINDOW; i++) begin
      rank = 0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j < i) begin
          if (win[j] <= win[i]) rank = rank + 1;
        end else if (j > i) begin
          if (win[j] < win[i]) rank = rank + 1;
        end
      end
      is_mid[i] = (rank == MEDIAN_RANK);
    end
  end

  // Pick the middle element with an and-or mux.
  always_comb begin
    med = '0;
    for (int i = 0; i < WINDOW; i++) begin
      med = med | (win[i] & {PIXEL_BITS{is_mid[i]}});
    end
  end

  assign has_y = (column_count >= COL_TWO);
  assign y     = (column_count >= COL_FULL) ? med : raw_first;

  // Lay out the beats this input causes, in output order.
  always_comb begin
    res[0]   = y;
    res[1]   = raw_second;
    res[2]   = x;
    push_ctl = '{count: RUN_NONE, row_end: end_of_row};
    if (has_y) begin
      push_ctl.count = end_of_row ? RUN_THREE : RUN_ONE;
    end else if (end_of_row) begin
      if (column_count >= COL_ONE) begin
        res[0]         = raw_second;
        res[1]         = x;
        push_ctl.count = RUN_TWO;
      end else begin
        res[0]         = x;
        push_ctl.count = RUN_ONE;
      end
    end
  end

  for (genvar k = 0; k < MAX_RESULTS; k++) begin : g_pack
    assign push_pix[k*PIXEL_BITS +: PIXEL_BITS] = res[k];
  end

  assign push = accept && (push_ctl.count != RUN_NONE);

  // Column count clears at the end of a row and saturates once full.
  always_comb begin
    column_count_next = column_count;
    if (end_of_row) begin
      column_count_next = '0;
    end else if (column_count < COL_FULL) begin
      column_count_next = column_count + COL_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out_two <= '0;
      prev_out_one <= '0;
      raw_first    <= '0;
      raw_second   <= '0;
      column_count <= '0;
    end else if (accept) begin
      if (has_y) begin
        prev_out_two <= prev_out_one;
        prev_out_one <= y;
      end
      raw_first    <= raw_second;
      raw_second   <= x;
      column_count <= column_count_next;
    end
  end

endmodule

// ===== design/rm5_queue.sv =====
`timescale 1ns / 1ps

module rm5_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       not_empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic                do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_BITS'(DEPTH));
  assign rdata     = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/rm5_back.sv =====
`timescale 1ns / 1ps

module rm5_back import rm5_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  logic [MAX_RESULTS*PIXEL_BITS-1:0] head_pix,
  input  run_ctl_t                          head_ctl,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [FIELD_BITS-1:0]             out_pixel,
  output logic                              out_row_end,
  output logic                              out_last_of_run
);

  logic [RUN_BITS-1:0]   beat_idx;
  logic [PIXEL_BITS-1:0] res [MAX_RESULTS];
  logic                  is_last;
  logic                  out_fire;

  for (genvar k = 0; k < MAX_RESULTS; k++) begin : g_unpack
    assign res[k] = head_pix[k*PIXEL_BITS +: PIXEL_BITS];
  end

  // The head entry is shown one beat at a time.
  assign is_last         = (beat_idx == head_ctl.count - 1'b1);
  assign out_valid       = head_valid;
  assign out_pixel       = FIELD_BITS'(res[beat_idx]);
  assign out_last_of_run = is_last;
  assign out_row_end     = is_last && head_ctl.row_end;
  assign out_fire        = out_valid && out_ready;
  assign pop             = out_fire && is_last;

  // Beat index steps through the run and returns to zero on its last beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_idx <= '0;
    end else if (out_fire) begin
      beat_idx <= is_last ? '0 : beat_idx + 1'b1;
    end
  end

endmodule

// ===== design/recursive_median5_row_filter.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// input    in_valid / in_ready    pixel, end_of_row
// output   out_valid / out_ready  out_pixel, out_row_end, out_last_of_run
//
// One input beat is accepted per cycle while the run queue has room; the median
// feedback closes through the two result registers in the front.
// Each queued run drains at one output beat per cycle while out_ready is high, so
// an end-of-row input holds the output side for all of its beats, up to three.
// An accepted input's beats are registered in the run queue before they are shown.
// Reset clears the row state, the queue and the beat index.
// Output stalls fill the queue and only then drop in_ready.

module recursive_median5_row_filter import rm5_pkg::*; #(
  parameter int PIXEL_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_BITS-1:0] pixel,
  input  logic                  end_of_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_BITS-1:0] out_pixel,
  output logic                  out_row_end,
  output logic                  out_last_of_run
);

  localparam int PIX_VEC  = MAX_RESULTS * PIXEL_BITS;
  localparam int Q_WIDTH  = CTL_BITS + PIX_VEC;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_not_empty;
  logic [CNT_BITS-1:0] q_count;
  logic [PIX_VEC-1:0]  push_pix;
  run_ctl_t            push_ctl;
  logic [Q_WIDTH-1:0]  q_wdata;
  logic [Q_WIDTH-1:0]  q_rdata;
  run_ctl_t            head_ctl;
  logic [PIX_VEC-1:0]  head_pix;

  rm5_front #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .end_of_row(end_of_row),
    .q_full    (q_full),
    .push      (q_push),
    .push_pix  (push_pix),
    .push_ctl  (push_ctl)
  );

  assign q_wdata = {push_ctl, push_pix};

  rm5_queue #(
    .WIDTH(Q_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_not_empty),
    .full     (q_full),
    .count    (q_count)
  );

  assign head_ctl = run_ctl_t'(q_rdata[Q_WIDTH-1:PIX_VEC]);
  assign head_pix = q_rdata[PIX_VEC-1:0];

  rm5_back #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_not_empty),
    .head_pix       (head_pix),
    .head_ctl       (head_ctl),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_row_end    (out_row_end),
    .out_last_of_run(out_last_of_run)
  );

`ifndef SYNTH
  // Occupancy never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("run queue occupancy out of range");

  // A push without a pop grows the queue by exactly one entry.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |=> q_count == $past(q_count) + 1'b1)
    else $error("run queue count did not follow a push");

  // A row end is always the final beat of its run.
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_row_end |-> out_last_of_run)
    else $error("row end beat is not the last of its run");

  // A queued entry always carries at least one beat.
  a_nonempty_run: assert property (@(posedge clk) disable iff (rst)
    q_not_empty |-> head_ctl.count != RUN_NONE)
    else $error("empty run reached the output side");
`endif

endmodule
